/* rtl/srec_pkg.sv */
package srec_pkg;

  localparam int ADDR_WIDTH = 32;
  localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_WIDTH) - 64'd1);

  localparam logic [7:0] CHAR_TYPE_S1 = 8'h31;
  localparam logic [7:0] CHAR_TYPE_S2 = 8'h32;
  localparam logic [7:0] CHAR_TYPE_S3 = 8'h33;

  localparam logic [2:0] ADDR_BYTES_S1 = 3'd2;
  localparam logic [2:0] ADDR_BYTES_S2 = 3'd3;
  localparam logic [2:0] ADDR_BYTES_S3 = 3'd4;

  typedef struct packed {
    logic        valid;
    logic [31:0] byte_address;
    logic [7:0]  byte_value;
  } srec_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nibble;
  } srec_hex_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic srec_hex_t hex_decode(input logic [7:0] c);
    srec_hex_t h;
    h.ok     = 1'b1;
    h.nibble = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nibble = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.nibble = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.nibble = 4'(c - 8'h61 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

/* rtl/srec_parser.sv */
module srec_parser
  import srec_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         char_accept,
  input  logic [7:0]   char_in,
  input  logic [31:0]  load_offset,
  output srec_result_t result
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TYPE,
    PH_COUNT,
    PH_ADDR,
    PH_DATA,
    PH_SKIP
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  abt_r, abt_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [31:0] rec_addr_r, rec_addr_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic        pend_r, pend_nxt;
  logic [7:0]  seen_r, seen_nxt;

  srec_hex_t   hex;
  logic [7:0]  byte_val;
  logic [3:0]  used;
  logic [7:0]  data_total;
  logic [8:0]  seen_inc;

  always_comb begin
    hex        = hex_decode(char_in);
    byte_val   = {hi_r, hex.nibble};
    used       = {1'b0, abt_r} + 4'd1;
    data_total = (count_r > {4'd0, used}) ? count_r - {4'd0, used} : 8'd0;
    seen_inc   = {1'b0, seen_r} + 9'd1;

    phase_nxt    = phase_r;
    abt_nxt      = abt_r;
    count_nxt    = count_r;
    rec_addr_nxt = rec_addr_r;
    hi_nxt       = hi_r;
    pend_nxt     = pend_r;
    seen_nxt     = seen_r;

    result.valid        = 1'b0;
    result.byte_address = (rec_addr_r + {24'd0, seen_r} - load_offset) & ADDR_MASK;
    result.byte_value   = byte_val;

    if (is_space(char_in)) begin
      phase_nxt = PH_IDLE;
      pend_nxt  = 1'b0;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          phase_nxt = PH_TYPE;
        end
        PH_TYPE: begin
          priority if (char_in == CHAR_TYPE_S1) abt_nxt = ADDR_BYTES_S1;
          else if (char_in == CHAR_TYPE_S2) abt_nxt = ADDR_BYTES_S2;
          else if (char_in == CHAR_TYPE_S3) abt_nxt = ADDR_BYTES_S3;
          else abt_nxt = abt_r;
          if (char_in == CHAR_TYPE_S1 || char_in == CHAR_TYPE_S2 ||
              char_in == CHAR_TYPE_S3) begin
            phase_nxt    = PH_COUNT;
            pend_nxt     = 1'b0;
            seen_nxt     = 8'd0;
            rec_addr_nxt = 32'd0;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_COUNT, PH_ADDR, PH_DATA: begin
          if (!hex.ok) begin
            phase_nxt = PH_SKIP;
            pend_nxt  = 1'b0;
          end else if (!pend_r) begin
            hi_nxt   = hex.nibble;
            pend_nxt = 1'b1;
          end else begin
            pend_nxt = 1'b0;
            if (phase_r == PH_COUNT) begin
              count_nxt = byte_val;
              seen_nxt  = 8'd0;
              phase_nxt = PH_ADDR;
            end else if (phase_r == PH_ADDR) begin
              rec_addr_nxt = {rec_addr_r[23:0], byte_val};
              seen_nxt     = seen_inc[7:0];
              if (seen_inc >= {6'd0, abt_r}) begin
                seen_nxt  = 8'd0;
                phase_nxt = (data_total == 8'd0) ? PH_SKIP : PH_DATA;
              end
            end else begin
              result.valid = 1'b1;
              seen_nxt     = seen_inc[7:0];
              if (seen_inc >= {1'b0, data_total}) phase_nxt = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
        end
        default: begin
          phase_nxt = PH_SKIP;
        end
      endcase
    end

    if (!char_accept) result.valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      abt_r      <= 3'd0;
      count_r    <= 8'd0;
      rec_addr_r <= 32'd0;
      hi_r       <= 4'd0;
      pend_r     <= 1'b0;
      seen_r     <= 8'd0;
    end else if (char_accept) begin
      phase_r    <= phase_nxt;
      abt_r      <= abt_nxt;
      count_r    <= count_nxt;
      rec_addr_r <= rec_addr_nxt;
      hi_r       <= hi_nxt;
      pend_r     <= pend_nxt;
      seen_r     <= seen_nxt;
    end
  end

  // a byte only comes out on the second digit of a data pair
  a_result_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    result.valid |-> (phase_r == PH_DATA) && pend_r)
    else $error("result outside data phase");

  // whitespace always drops a half-built byte
  a_space_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (char_accept && is_space(char_in)) |=> (!pend_r && phase_r == PH_IDLE))
    else $error("whitespace did not end record");

endmodule

/* rtl/srec_out_reg.sv */
module srec_out_reg
  import srec_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  srec_result_t result,
  input  logic         out_ready,
  output logic         slot_free,
  output logic         out_valid,
  output logic [31:0]  out_byte_address,
  output logic [7:0]   out_byte_value
);

  logic        valid_r;
  logic [31:0] addr_r;
  logic [7:0]  value_r;

  assign slot_free        = !valid_r || out_ready;
  assign out_valid        = valid_r;
  assign out_byte_address = addr_r;
  assign out_byte_value   = value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (result.valid) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      addr_r  <= result.byte_address;
      value_r <= result.byte_value;
    end
  end

  // a new result may only land when the slot is free or draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    result.valid |-> slot_free)
    else $error("result overwrote a pending transaction");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_ready && !result.valid) |=> !valid_r)
    else $error("output not released after transaction");

endmodule

/* rtl/srec_record_decoder_core.sv */
// S-record decoder: takes one ASCII character per transaction and emits one
// (address, byte) transaction for every data byte of S1/S2/S3 records. Each
// character is decoded combinationally, so a new character is accepted every
// cycle; in_ready falls only while a decoded byte waits at the output and
// out_ready is low. Address = record address + byte index - load offset,
// modulo 2^32. Checksums are not verified; other record types and records
// with bad hex digits are skipped up to the next whitespace. Write
// cfg_wr_data with cfg_wr_en only while no characters are in flight.
module srec_record_decoder_core
  import srec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_byte_address,
  output logic [7:0]  out_byte_value,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic [31:0]  load_offset_r;
  logic         slot_free;
  logic         char_accept;
  srec_result_t result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_offset_r <= 32'd0;
    end else if (cfg_wr_en) begin
      load_offset_r <= cfg_wr_data;
    end
  end

  assign in_ready    = slot_free;
  assign char_accept = in_valid && slot_free;

  srec_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .char_accept (char_accept),
    .char_in     (in_char_in),
    .load_offset (load_offset_r),
    .result      (result)
  );

  srec_out_reg u_out_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .result           (result),
    .out_ready        (out_ready),
    .slot_free        (slot_free),
    .out_valid        (out_valid),
    .out_byte_address (out_byte_address),
    .out_byte_value   (out_byte_value)
  );

endmodule

/* bench/srec_record_decoder_core_tb.sv */
module srec_record_decoder_core_tb;
  import srec_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 6;
  localparam int CHARS_PER_PHASE = 130;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MARK  = 8'h53;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_TYPE, SCAN_COUNT, SCAN_ADDR, SCAN_DATA, SCAN_SKIP
  } scan_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [7:0]  value;
  } placed_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char_in;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_byte_address;
  logic [7:0]  out_byte_value;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  srec_record_decoder_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_in      (in_char_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_address(out_byte_address),
    .out_byte_value  (out_byte_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  // decoder shadow state
  scan_t       scan;
  logic [2:0]  addr_len;
  logic [7:0]  rec_count;
  logic [31:0] rec_addr;
  logic [3:0]  hi_nib;
  logic        nib_held;
  logic [7:0]  byte_idx;
  logic [31:0] offset_shadow;

  placed_byte_t due_bytes[$];
  logic [7:0]   pending_chars[$];
  logic [7:0]   rec_buf[$];

  int chars_queued;
  int chars_accepted;
  int mismatches;
  int cycle_count;
  int burst_left;
  int gap_left;
  int stall_mode;
  int ready_tick;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  function automatic int payload_len();
    int used;
    used = int'(addr_len) + 1;
    if (int'(rec_count) <= used) return 0;
    return int'(rec_count) - used;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic decode_char(input logic [7:0] c);
    int nib;
    logic [7:0] b;
    placed_byte_t e;
    nib = hex_nibble(c);
    if (is_blank(c)) begin
      scan = SCAN_IDLE;
      nib_held = 1'b0;
    end else begin
      case (scan)
        SCAN_IDLE: scan = SCAN_TYPE;
        SCAN_TYPE: begin
          if (c == CHAR_TYPE_S1) begin
            addr_len = ADDR_BYTES_S1;
            scan = SCAN_COUNT;
          end else if (c == CHAR_TYPE_S2) begin
            addr_len = ADDR_BYTES_S2;
            scan = SCAN_COUNT;
          end else if (c == CHAR_TYPE_S3) begin
            addr_len = ADDR_BYTES_S3;
            scan = SCAN_COUNT;
          end else begin
            scan = SCAN_SKIP;
          end
          if (scan == SCAN_COUNT) begin
            nib_held = 1'b0;
            byte_idx = 8'd0;
            rec_addr = 32'd0;
          end
        end
        SCAN_COUNT, SCAN_ADDR, SCAN_DATA: begin
          if (nib < 0) begin
            scan = SCAN_SKIP;
            nib_held = 1'b0;
          end else if (!nib_held) begin
            hi_nib = nib[3:0];
            nib_held = 1'b1;
          end else begin
            nib_held = 1'b0;
            b = {hi_nib, nib[3:0]};
            if (scan == SCAN_COUNT) begin
              rec_count = b;
              byte_idx = 8'd0;
              scan = SCAN_ADDR;
            end else if (scan == SCAN_ADDR) begin
              rec_addr = {rec_addr[23:0], b};
              byte_idx++;
              if (byte_idx >= addr_len) begin
                byte_idx = 8'd0;
                scan = (payload_len() == 0) ? SCAN_SKIP : SCAN_DATA;
              end
            end else begin
              e.addr = (rec_addr + 32'(byte_idx) - offset_shadow) & ADDR_MASK;
              e.value = b;
              due_bytes.push_back(e);
              byte_idx++;
              if (int'(byte_idx) >= payload_len()) scan = SCAN_SKIP;
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  // sender: bursts of characters separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      scan = SCAN_IDLE;
      addr_len = 3'd0;
      rec_count = 8'd0;
      rec_addr = 32'd0;
      hi_nib = 4'd0;
      nib_held = 1'b0;
      byte_idx = 8'd0;
      offset_shadow = 32'd0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (cfg_wr_en) offset_shadow = cfg_wr_data;
      if (in_valid && in_ready) begin
        decode_char(in_char_in);
        chars_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          in_valid <= 1'b1;
          in_char_in <= pending_chars.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each transaction, stalls in changing modes
  always @(posedge clk) begin
    placed_byte_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_mode = 0;
      ready_tick = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %h at %h",
                                    out_byte_value, out_byte_address));
        end else begin
          e = due_bytes.pop_front();
          if (out_byte_address !== e.addr)
            report_mismatch($sformatf("address %h, want %h",
                                      out_byte_address, e.addr));
          if (out_byte_value !== e.value)
            report_mismatch($sformatf("value %h at %h, want %h",
                                      out_byte_value, e.addr, e.value));
        end
      end
      ready_tick++;
      if (ready_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (ready_tick[2:0] != 3'd5 && ready_tick[2:0] != 3'd6);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(input logic [7:0] c);
    pending_chars.push_back(c);
    chars_queued++;
  endtask

  task automatic send_token(input string s, input logic [7:0] ws);
    for (int i = 0; i < s.len(); i++) send(s[i]);
    send(ws);
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 7))
      0: return CH_TAB;
      1: return CH_LF;
      2: return CH_VT;
      3: return CH_FF;
      4: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    if ($urandom_range(0, 1) == 1) return 8'("a" + n - 4'd10);
    return 8'("A" + n - 4'd10);
  endfunction

  // any non-blank character that is not a hex digit
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (is_blank(c) || hex_nibble(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] bad_type_char();
    logic [7:0] c;
    do c = ($urandom_range(0, 1) == 1) ? 8'($urandom_range("0", "9"))
                                        : 8'($urandom_range(0, 255));
    while (is_blank(c) || c == CHAR_TYPE_S1 || c == CHAR_TYPE_S2 ||
           c == CHAR_TYPE_S3);
    return c;
  endfunction

  function automatic int addr_len_of(input logic [7:0] t);
    if (t == CHAR_TYPE_S2) return int'(ADDR_BYTES_S2);
    if (t == CHAR_TYPE_S3) return int'(ADDR_BYTES_S3);
    return int'(ADDR_BYTES_S1);
  endfunction

  task automatic buf_hex_byte(input logic [7:0] b);
    rec_buf.push_back(hex_char(b[7:4]));
    rec_buf.push_back(hex_char(b[3:0]));
  endtask

  task automatic build_record(input logic [7:0] t, input logic [7:0] cnt,
                              input logic [31:0] a, input int ndata,
                              input int tail);
    logic [7:0] m;
    rec_buf.delete();
    m = CH_MARK;
    if ($urandom_range(0, 7) == 0) begin
      do m = 8'($urandom_range(0, 255));
      while (is_blank(m));
    end
    rec_buf.push_back(m);
    rec_buf.push_back(t);
    buf_hex_byte(cnt);
    for (int i = addr_len_of(t) - 1; i >= 0; i--) buf_hex_byte(a[8*i +: 8]);
    repeat (ndata) buf_hex_byte(8'($urandom_range(0, 255)));
    repeat (tail) rec_buf.push_back(hex_char(4'($urandom_range(0, 15))));
  endtask

  task automatic flush_record();
    foreach (rec_buf[i]) send(rec_buf[i]);
    send(blank_char());
    if ($urandom_range(0, 7) == 0) send(blank_char());
  endtask

  task automatic random_traffic(input int n_chars);
    int target;
    int kind;
    int len;
    int ndata;
    int tail;
    int k;
    logic [7:0] t;
    logic [7:0] cnt;
    logic [31:0] a;
    target = chars_queued + n_chars;
    while (chars_queued < target) begin
      kind = $urandom_range(0, 99);
      t = 8'(CHAR_TYPE_S1 + 8'($urandom_range(0, 2)));
      if (kind >= 88 && kind < 94) t = bad_type_char();
      len = addr_len_of(t);
      case ($urandom_range(0, 7))
        0: a = 32'hFFFF_FFFF;
        1: a = 32'h0000_0000;
        default: a = $urandom;
      endcase
      ndata = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
      cnt = 8'(len + 1 + ndata);
      if ($urandom_range(0, 9) == 0) cnt = 8'($urandom_range(0, 255));
      tail = ($urandom_range(0, 9) < 7) ? 2 : $urandom_range(0, 5);
      if (kind < 94) begin
        build_record(t, cnt, a, ndata, tail);
        if (kind >= 70 && kind < 80) begin
          k = $urandom_range(2, rec_buf.size() - 1);
          rec_buf[k] = junk_char();
        end else if (kind >= 80 && kind < 88) begin
          k = $urandom_range(1, rec_buf.size() - 1);
          while (rec_buf.size() > k) void'(rec_buf.pop_back());
        end
        flush_record();
      end else begin
        repeat ($urandom_range(1, 8)) send(8'($urandom_range(0, 255)));
        send(blank_char());
      end
    end
  endtask

  // wait out all characters and results; stray leftovers count as failures
  task automatic drain_results();
    int waited;
    waited = 0;
    while (chars_accepted != chars_queued) @(negedge clk);
    while (due_bytes.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (6) @(negedge clk);
    if (due_bytes.size() != 0) begin
      report_mismatch($sformatf("%0d bytes never came out", due_bytes.size()));
      due_bytes.delete();
    end
  endtask

  task automatic write_offset(input logic [31:0] v);
    @(posedge clk);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_in = 8'd0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 32'd0;
    chars_queued = 0;
    chars_accepted = 0;
    mismatches = 0;
    cycle_count = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    write_offset(32'd0);
    send_token("S104ffff00", CH_SPACE);
    send_token("S2050000017F5a", CH_CR);       // checksum and beyond ignored
    send_token("S307FFFFFFFFFF80", CH_LF);     // address wraps past the top
    send_token("S00300", CH_VT);
    send_token("S9030000FC", CH_FF);
    send_token("xz0412340a", CH_SPACE);        // non-digit type
    send_token("a104ABCDef", CH_SPACE);        // mark is not checked
    send_token("S1060010AB4", CH_TAB);         // half byte dropped at blank
    send_token("S1060010CD3x12", CH_SPACE);    // bad digit after half byte
    send_token("S10300001234", CH_LF);         // count leaves no data
    send_token("S100FFFF12", CH_SPACE);
    send_token("S1FF12340102", CH_LF);         // token ends before its count is used up
    send(CH_SPACE);
    drain_results();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: ;
        1: write_offset(32'hFFFF_FFFF);
        2: write_offset($urandom);
        3: write_offset(32'h8000_0000);
        4: write_offset(32'h0000_0001);
        default: write_offset($urandom);
      endcase
      random_traffic(CHARS_PER_PHASE);
      drain_results();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/srec_pkg.sv
rtl/srec_parser.sv
rtl/srec_out_reg.sv
rtl/srec_record_decoder_core.sv
bench/srec_record_decoder_core_tb.sv
